FILE: hdl/lar_pkg.sv
// Shared types and constants for the light attenuation range pipeline.
// No dependencies; used by light_attenuation_range and lar_front under hdl/.
`timescale 1ns / 1ps

package lar_pkg;

  localparam int unsigned ColW    = 16;  // colour channel, Q4.12
  localparam int unsigned IntW    = 24;  // intensity, Q16.8
  localparam int unsigned CoefW   = 24;  // coefficient, Q8.16
  localparam int unsigned PeakW   = 44;  // 16 * colour * intensity
  localparam int unsigned RadW    = 70;  // L^2 + 4*Q*M
  localparam int unsigned Div1W   = 60;  // first divider numerator / quotient
  localparam int unsigned SqrtW   = 86;  // radicand of the root unit
  localparam int unsigned RootW   = 43;  // root width
  localparam int unsigned DistW   = 32;  // Q24.8 result

  typedef enum logic [2:0] {
    MODE_NONE,    // no coefficient present
    MODE_CONST,   // only the constant term present
    MODE_NOROOT,  // constant above peak
    MODE_SAT,     // zero divisor
    MODE_SQRT,    // quadratic term, no linear term
    MODE_QUAD,    // quadratic and linear terms
    MODE_LIN      // linear term, maybe with constant
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOATT,
    ST_NOROOT,
    ST_SAT
  } status_e;

  typedef struct packed {
    logic [CoefW-1:0] atten_quadratic;
    logic [CoefW-1:0] atten_linear;
    logic [CoefW-1:0] atten_constant;
    logic [IntW-1:0]  intensity_candela;
    logic [ColW-1:0]  colour_blue;
    logic [ColW-1:0]  colour_green;
    logic [ColW-1:0]  colour_red;
  } in_item_t;

  typedef struct packed {
    mode_e            mode;
    logic [RadW-1:0]  rad;
    logic [Div1W-1:0] num;
    logic [CoefW-1:0] den;
    logic [CoefW-1:0] lin;
    logic [CoefW-1:0] quad;
  } fr_out_t;

  typedef struct packed {
    mode_e            mode;
    logic [RadW-1:0]  rad;
    logic [CoefW-1:0] lin;
    logic [CoefW-1:0] quad;
  } d1_side_t;

  typedef struct packed {
    mode_e            mode;
    logic [CoefW-1:0] lin;
    logic [CoefW-1:0] quad;
    logic [Div1W-1:0] quo;
  } sq_side_t;

  typedef struct packed {
    mode_e            mode;
    logic [Div1W-1:0] res;
  } d2_side_t;

endpackage

FILE: hdl/light_attenuation_range.sv
// Top level of the light attenuation range pipeline.
// Depends on lar_pkg, lar_front, lar_div and lar_sqrt.
`timescale 1ns / 1ps

// Computes, per light, the distance at which constant + linear*d + quadratic*d^2
// reaches 256 * max(colour) * intensity, in Q24.8, with a status code in tuser.
// Fully pipelined: one light per clock unless the pipeline holds (5 front-end stages,
// 60 stages of the first divider, 43 root stages, 1 subtract stage, 43 stages
// of the second divider, 1 output register). The whole pipeline advances as
// one; it holds only while a result sits in the output register untaken, so
// s_axis_tready_o is high whenever the output slot is free or being drained.
// The user must write zero_threshold through the cfg port only while the block
// is idle (unenforced by the block); reset value 1; cfg_ready_o is always high.
module light_attenuation_range (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [23:0]  cfg_data_i,     // zero_threshold
  // input stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [15:0] colour_red, [31:16] colour_green, [47:32] colour_blue,
  // [71:48] intensity_candela, [95:72] atten_constant,
  // [119:96] atten_linear, [143:120] atten_quadratic
  input  logic [143:0] s_axis_tdata_i,
  // output stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [31:0]  m_axis_tdata_o,  // [31:0] max_distance
  output logic [1:0]   m_axis_tuser_o   // [1:0] status
);

  localparam int unsigned D1SW = $bits(lar_pkg::d1_side_t);
  localparam int unsigned SQSW = $bits(lar_pkg::sq_side_t);
  localparam int unsigned D2SW = $bits(lar_pkg::d2_side_t);

  logic        pipe_en;
  logic [23:0] thresh_q;

  // Single stall for the entire pipe: move whenever the output slot frees.
  assign pipe_en         = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = pipe_en;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= 24'd1;
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  // ---- front end ----
  lar_pkg::in_item_t item;
  lar_pkg::fr_out_t  fr_data;
  logic              fr_valid;

  assign item = lar_pkg::in_item_t'(s_axis_tdata_i);

  lar_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (s_axis_tvalid_i),
    .item_i   (item),
    .thresh_i (thresh_q),
    .valid_o  (fr_valid),
    .data_o   (fr_data)
  );

  // ---- first divider: M*2^16/Q (root form) or M*2^8/L (linear form) ----
  lar_pkg::d1_side_t d1_in, d1_out;
  logic [D1SW-1:0]   d1_out_vec;
  logic [59:0]       d1_quo;
  logic              d1_valid;

  assign d1_in.mode = fr_data.mode;
  assign d1_in.rad  = fr_data.rad;
  assign d1_in.lin  = fr_data.lin;
  assign d1_in.quad = fr_data.quad;

  lar_div #(.NW(lar_pkg::Div1W), .DW(lar_pkg::CoefW), .SW(D1SW)) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (fr_valid),
    .num_i   (fr_data.num),
    .den_i   (fr_data.den),
    .side_i  (D1SW'(d1_in)),
    .valid_o (d1_valid),
    .quo_o   (d1_quo),
    .side_o  (d1_out_vec)
  );

  assign d1_out = lar_pkg::d1_side_t'(d1_out_vec);

  // ---- square root: of the quotient, or of (L^2 + 4QM) * 2^16 ----
  lar_pkg::sq_side_t sq_in, sq_out;
  logic [SQSW-1:0]   sq_out_vec;
  logic [85:0]       sq_rad;
  logic [42:0]       sq_root;
  logic              sq_valid;

  assign sq_rad = (d1_out.mode == lar_pkg::MODE_SQRT) ? {26'b0, d1_quo} : {d1_out.rad, 16'b0};

  assign sq_in.mode = d1_out.mode;
  assign sq_in.lin  = d1_out.lin;
  assign sq_in.quad = d1_out.quad;
  assign sq_in.quo  = d1_quo;

  lar_sqrt #(.RW(lar_pkg::SqrtW), .SW(SQSW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (d1_valid),
    .rad_i   (sq_rad),
    .side_i  (SQSW'(sq_in)),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_out_vec)
  );

  assign sq_out = lar_pkg::sq_side_t'(sq_out_vec);

  // ---- subtract stage: S - 256*L, clamped at zero ----
  logic              br_valid_q;
  lar_pkg::d2_side_t br_side_q;
  logic [42:0]       br_num_q, l256;
  logic [24:0]       br_den_q;

  assign l256 = {11'b0, sq_out.lin, 8'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_valid_q <= 1'b0;
    end else if (pipe_en) begin
      br_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      br_side_q.mode <= sq_out.mode;
      br_side_q.res  <= (sq_out.mode == lar_pkg::MODE_SQRT) ? {17'b0, sq_root} : sq_out.quo;
      br_num_q       <= (sq_root > l256) ? sq_root - l256 : '0;
      br_den_q       <= {sq_out.quad, 1'b0};
    end
  end

  // ---- second divider: (S - 256L) / 2Q ----
  lar_pkg::d2_side_t d2_out;
  logic [D2SW-1:0]   d2_out_vec;
  logic [42:0]       d2_quo;
  logic              d2_valid;

  lar_div #(.NW(lar_pkg::RootW), .DW(lar_pkg::CoefW + 1), .SW(D2SW)) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (br_valid_q),
    .num_i   (br_num_q),
    .den_i   (br_den_q),
    .side_i  (D2SW'(br_side_q)),
    .valid_o (d2_valid),
    .quo_o   (d2_quo),
    .side_o  (d2_out_vec)
  );

  assign d2_out = lar_pkg::d2_side_t'(d2_out_vec);

  // ---- result select and saturation ----
  logic [59:0]       wide_dist;
  logic [31:0]       dist_d, dist_q;
  lar_pkg::status_e  st_d, st_q;
  logic              out_valid_q;

  always_comb begin
    wide_dist = '0;
    st_d      = lar_pkg::ST_OK;
    case (d2_out.mode)
      lar_pkg::MODE_NONE:   st_d = lar_pkg::ST_NOATT;
      lar_pkg::MODE_CONST:  st_d = lar_pkg::ST_OK;
      lar_pkg::MODE_NOROOT: st_d = lar_pkg::ST_NOROOT;
      lar_pkg::MODE_SAT:    st_d = lar_pkg::ST_SAT;
      lar_pkg::MODE_QUAD:   wide_dist = {17'b0, d2_quo};
      lar_pkg::MODE_SQRT,
      lar_pkg::MODE_LIN:    wide_dist = d2_out.res;
      default:              st_d = lar_pkg::ST_SAT;
    endcase
    if (st_d == lar_pkg::ST_SAT || wide_dist[59:32] != '0) begin
      dist_d = '1;
      st_d   = lar_pkg::ST_SAT;
    end else begin
      dist_d = wide_dist[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dist_q <= dist_d;
      st_q   <= st_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = dist_q;
  assign m_axis_tuser_o  = st_q;

  // ---- checks ----
  a_sat_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && st_q == lar_pkg::ST_SAT) |-> dist_q == 32'hFFFF_FFFF)
    else $error("saturated result without full-scale distance");

  a_zero_dist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (st_q == lar_pkg::ST_NOATT || st_q == lar_pkg::ST_NOROOT))
      |-> dist_q == '0)
    else $error("no-attenuation or no-root result with nonzero distance");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> ($stable(d2_valid) && $stable(fr_valid)))
    else $error("pipeline valid moved during stall");

endmodule

FILE: hdl/lar_front.sv
// Front end: coefficient magnitudes, peak term, mode select and radicand.
// Five register stages. Depends on lar_pkg.
`timescale 1ns / 1ps

module lar_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  lar_pkg::in_item_t item_i,
  input  logic [23:0]       thresh_i,
  output logic              valid_o,
  output lar_pkg::fr_out_t  data_o
);

  // stage 1
  logic        v1_q;
  logic [15:0] c1_q;
  logic [23:0] i1_q, k1_q, l1_q, q1_q;
  logic        kp1_q, lp1_q, qp1_q;
  logic [15:0] cmax;
  logic [23:0] kmag, lmag, qmag;

  always_comb begin
    cmax = item_i.colour_red;
    if (item_i.colour_green > cmax) cmax = item_i.colour_green;
    if (item_i.colour_blue > cmax) cmax = item_i.colour_blue;
  end

  assign kmag = item_i.atten_constant[23]  ? 24'(-item_i.atten_constant)  : item_i.atten_constant;
  assign lmag = item_i.atten_linear[23]    ? 24'(-item_i.atten_linear)    : item_i.atten_linear;
  assign qmag = item_i.atten_quadratic[23] ? 24'(-item_i.atten_quadratic) : item_i.atten_quadratic;

  // stage 2
  logic        v2_q;
  logic [39:0] prod2_q;
  logic [47:0] ls2_q;
  logic [23:0] k2_q, l2_q, q2_q;
  logic        kp2_q, lp2_q, qp2_q;

  // stage 3
  logic              v3_q;
  lar_pkg::mode_e    mode3_q, mode3_d;
  logic [43:0]       m3_q, pr3;
  logic [23:0]       l3_q, q3_q;
  logic [47:0]       ls3_q;

  assign pr3 = {prod2_q, 4'b0};

  always_comb begin
    if (!kp2_q && !lp2_q && !qp2_q)       mode3_d = lar_pkg::MODE_NONE;
    else if (!qp2_q && !lp2_q)            mode3_d = lar_pkg::MODE_CONST;
    else if ({20'b0, k2_q} > pr3)         mode3_d = lar_pkg::MODE_NOROOT;
    else if (qp2_q && q2_q == '0)         mode3_d = lar_pkg::MODE_SAT;
    else if (qp2_q && !lp2_q)             mode3_d = lar_pkg::MODE_SQRT;
    else if (qp2_q)                       mode3_d = lar_pkg::MODE_QUAD;
    else if (l2_q == '0)                  mode3_d = lar_pkg::MODE_SAT;
    else                                  mode3_d = lar_pkg::MODE_LIN;
  end

  // stage 4: Q*M in two partial products
  logic           v4_q;
  lar_pkg::mode_e mode4_q;
  logic [43:0]    m4_q;
  logic [45:0]    p0_4_q, p1_4_q;
  logic [23:0]    l4_q, q4_q;
  logic [47:0]    ls4_q;

  // stage 5
  logic           v5_q;
  logic [67:0]    qm5;
  logic [69:0]    rad5;

  assign qm5  = {p1_4_q, 22'b0} + {22'b0, p0_4_q};
  assign rad5 = {qm5, 2'b0} + {22'b0, ls4_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q    <= cmax;
      i1_q    <= item_i.intensity_candela;
      k1_q    <= kmag;
      l1_q    <= lmag;
      q1_q    <= qmag;
      kp1_q   <= kmag >= thresh_i;
      lp1_q   <= lmag >= thresh_i;
      qp1_q   <= qmag >= thresh_i;

      prod2_q <= 40'(c1_q) * 40'(i1_q);
      ls2_q   <= 48'(l1_q) * 48'(l1_q);
      k2_q    <= k1_q;
      l2_q    <= l1_q;
      q2_q    <= q1_q;
      kp2_q   <= kp1_q;
      lp2_q   <= lp1_q;
      qp2_q   <= qp1_q;

      mode3_q <= mode3_d;
      m3_q    <= pr3 - {20'b0, k2_q};
      l3_q    <= l2_q;
      q3_q    <= q2_q;
      ls3_q   <= ls2_q;

      mode4_q <= mode3_q;
      m4_q    <= m3_q;
      p0_4_q  <= 46'(q3_q) * 46'(m3_q[21:0]);
      p1_4_q  <= 46'(q3_q) * 46'(m3_q[43:22]);
      l4_q    <= l3_q;
      q4_q    <= q3_q;
      ls4_q   <= ls3_q;

      data_o.mode <= mode4_q;
      data_o.rad  <= rad5;
      data_o.num  <= (mode4_q == lar_pkg::MODE_SQRT) ? {m4_q, 16'b0} : {8'b0, m4_q, 8'b0};
      data_o.den  <= (mode4_q == lar_pkg::MODE_SQRT) ? q4_q : l4_q;
      data_o.lin  <= l4_q;
      data_o.quad <= q4_q;
    end
  end

  assign valid_o = v5_q;

endmodule

FILE: hdl/lar_div.sv
// Pipelined restoring divider, one quotient bit per stage, side data carried.
// No dependencies.
`timescale 1ns / 1ps

module lar_div #(
  parameter int unsigned NW = 60,
  parameter int unsigned DW = 24,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [NW-1:0] num_q  [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];
  logic [NW-1:0] vld_q;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [NW-1:0] pn;
    logic [DW-1:0] pr, pd;
    logic [SW-1:0] ps;
    logic          pv;
    logic [DW:0]   trial, rem_d;
    logic          ge;

    if (s == 0) begin : g_first
      assign pn = num_i;
      assign pr = '0;
      assign pd = den_i;
      assign ps = side_i;
      assign pv = valid_i;
    end else begin : g_next
      assign pn = num_q[s-1];
      assign pr = rem_q[s-1];
      assign pd = den_q[s-1];
      assign ps = side_q[s-1];
      assign pv = vld_q[s-1];
    end

    assign trial = {pr, pn[NW-1]};
    assign ge    = trial >= {1'b0, pd};
    assign rem_d = ge ? trial - {1'b0, pd} : trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s]  <= {pn[NW-2:0], ge};
        rem_q[s]  <= rem_d[DW-1:0];
        den_q[s]  <= pd;
        side_q[s] <= ps;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = num_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

FILE: hdl/lar_sqrt.sv
// Pipelined integer square root, one root bit per stage, side data carried.
// No dependencies.
`timescale 1ns / 1ps

module lar_sqrt #(
  parameter int unsigned RW = 86,
  parameter int unsigned SW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [RW-1:0]   rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);

  localparam int unsigned HW = RW / 2;

  logic [RW-1:0] rad_q  [HW];
  logic [HW:0]   rem_q  [HW];
  logic [HW-1:0] root_q [HW];
  logic [SW-1:0] side_q [HW];
  logic [HW-1:0] vld_q;

  for (genvar s = 0; s < HW; s++) begin : g_stage
    logic [RW-1:0] prad;
    logic [HW:0]   prem;
    logic [HW-1:0] proot;
    logic [SW-1:0] ps;
    logic          pv;
    logic [HW+2:0] cur, tr, rem_d;
    logic          ge;

    if (s == 0) begin : g_first
      assign prad  = rad_i;
      assign prem  = '0;
      assign proot = '0;
      assign ps    = side_i;
      assign pv    = valid_i;
    end else begin : g_next
      assign prad  = rad_q[s-1];
      assign prem  = rem_q[s-1];
      assign proot = root_q[s-1];
      assign ps    = side_q[s-1];
      assign pv    = vld_q[s-1];
    end

    assign cur   = {prem, prad[RW-1:RW-2]};
    assign tr    = {1'b0, proot, 2'b01};
    assign ge    = cur >= tr;
    assign rem_d = ge ? cur - tr : cur;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s]  <= {prad[RW-3:0], 2'b00};
        rem_q[s]  <= rem_d[HW:0];
        root_q[s] <= {proot[HW-2:0], ge};
        side_q[s] <= ps;
      end
    end
  end

  assign valid_o = vld_q[HW-1];
  assign root_o  = root_q[HW-1];
  assign side_o  = side_q[HW-1];

endmodule

FILE: tb/light_attenuation_range_test.sv
// Self-checking testbench for light_attenuation_range: stream driver, result monitor
// and an in-bench distance predictor. Depends on lar_pkg and the DUT only.
`timescale 1ns / 1ps

module light_attenuation_range_test;

  typedef struct packed {
    logic [31:0] distance;
    logic [1:0]  status;
  } range_res_t;

  localparam int unsigned WatchdogLimit = 3000;  // idle cycles before giving up
  localparam int unsigned DrainCycles   = 200;   // wait before the final verdict

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [23:0]  cfg_data_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [143:0] s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [31:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  lar_pkg::in_item_t light_q[$];      // lights waiting to be sent
  range_res_t        range_exp_q[$];  // predicted results, oldest first
  logic [23:0] thr_model;      // bench copy of zero_threshold
  bit          src_idle_en;    // gaps on the input side in this phase
  bit          snk_idle_en;    // stalls on the output side in this phase
  int unsigned errors;
  int unsigned idle_cycles;

  light_attenuation_range u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    // [15:0] red, [31:16] green, [47:32] blue, [71:48] intensity,
    // [95:72] constant, [119:96] linear, [143:120] quadratic
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),  // [31:0] max_distance
    .m_axis_tuser_o (m_axis_tuser_o)   // [1:0] status
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Magnitude of a signed Q8.16 coefficient; -2^23 maps to 2^23.
  function automatic logic [24:0] coef_abs(logic [23:0] raw);
    if (raw[23]) return 25'h1000000 - {1'b0, raw};
    return {1'b0, raw};
  endfunction

  // Floor of the square root, radicand below 2^86.
  function automatic logic [63:0] floor_sqrt(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int b = 42; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  // Cutoff distance and status for one light under threshold thr.
  function automatic range_res_t cutoff_range(lar_pkg::in_item_t it, logic [23:0] thr);
    range_res_t   res;
    logic [127:0] k, l, q, c, peak, rem, v, s, d;
    logic         kp, lp, qp, sat;
    k = 128'(coef_abs(it.atten_constant));
    l = 128'(coef_abs(it.atten_linear));
    q = 128'(coef_abs(it.atten_quadratic));
    kp = k >= thr;
    lp = l >= thr;
    qp = q >= thr;
    c = 128'(it.colour_red);
    if (it.colour_green > c) c = 128'(it.colour_green);
    if (it.colour_blue > c) c = 128'(it.colour_blue);
    peak = c * 128'(it.intensity_candela) * 16;
    d = '0;
    sat = 1'b0;
    res.status = lar_pkg::ST_OK;
    if (!kp && !lp && !qp) begin
      res.status = lar_pkg::ST_NOATT;
    end else if (!qp && !lp) begin
      d = '0;  // constant only
    end else if (k > peak) begin
      res.status = lar_pkg::ST_NOROOT;
    end else begin
      rem = peak - k;
      if (qp && q == 0) begin
        sat = 1'b1;  // zero divisor
      end else if (qp && !lp) begin
        d = 128'(floor_sqrt((rem << 16) / q));
      end else if (qp) begin
        v = (4 * q * rem + l * l) << 16;
        s = 128'(floor_sqrt(v));
        d = (s > 256 * l) ? (s - 256 * l) / (2 * q) : '0;
      end else if (l == 0) begin
        sat = 1'b1;
      end else begin
        d = (rem << 8) / l;
      end
    end
    if (sat || d > 128'hFFFF_FFFF) begin
      res.distance = 32'hFFFF_FFFF;
      res.status = lar_pkg::ST_SAT;
    end else begin
      res.distance = d[31:0];
    end
    return res;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input driver: one nonblocking write of tvalid per edge.
  int unsigned src_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      src_gap = 0;
    end else begin
      nxt_valid = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        range_exp_q.push_back(cutoff_range(lar_pkg::in_item_t'(s_axis_tdata_i), thr_model));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (light_q.size() > 0) begin
          s_axis_tdata_i <= light_q.pop_front();
          nxt_valid = 1'b1;
          src_gap = src_idle_en ? pick_gap() : 0;
        end
      end
      s_axis_tvalid_i <= nxt_valid;
    end
  end

  // Result monitor with random backpressure.
  always @(posedge clk_i or negedge rst_ni) begin
    range_res_t got, want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.distance = m_axis_tdata_o;
        got.status   = m_axis_tuser_o;
        if (range_exp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction distance=%h status=%0d", $time, got.distance,
                   got.status);
        end else begin
          want = range_exp_q.pop_front();
          if (got.distance !== want.distance) begin
            errors++;
            $display("%0t: max_distance expected %h actual %h", $time, want.distance,
                     got.distance);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          end
        end
      end
      m_axis_tready_i <= snk_idle_en ? (pick_gap() == 0) : 1'b1;
    end
  end

  // Watchdog: cycles without any transaction on either stream.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || cfg_valid_i) begin
      idle_cycles <= 0;
    end else if (light_q.size() > 0 || range_exp_q.size() > 0 || s_axis_tvalid_i) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [23:0] rand_coef();
    case ($urandom_range(0, 6))
      0:       return 24'd0;
      1:       return 24'($urandom_range(0, 600));
      2:       return -24'($urandom_range(0, 600));
      3:       return 24'h800000;
      4:       return 24'($urandom_range(1, 65536));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_colour();
    case ($urandom_range(0, 3))
      0:       return 16'hFFFF;
      1:       return 16'($urandom_range(0, 4096));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic lar_pkg::in_item_t make_light(logic [15:0] r, logic [15:0] g,
                                                   logic [15:0] b, logic [23:0] i,
                                                   logic [23:0] k, logic [23:0] l,
                                                   logic [23:0] q);
    lar_pkg::in_item_t it;
    it.colour_red = r;
    it.colour_green = g;
    it.colour_blue = b;
    it.intensity_candela = i;
    it.atten_constant = k;
    it.atten_linear = l;
    it.atten_quadratic = q;
    return it;
  endfunction

  task automatic queue_random(int unsigned n);
    lar_pkg::in_item_t it;
    repeat (n) begin
      it = make_light(rand_colour(), rand_colour(), rand_colour(),
                      ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 4096)) : 24'($urandom),
                      rand_coef(), rand_coef(), rand_coef());
      // mostly lights with some attenuation so the solving forms get exercised
      if ($urandom_range(0, 3) != 0 && it.atten_linear == 0 && it.atten_quadratic == 0)
        it.atten_quadratic = 24'($urandom_range(1, 8388607));
      light_q.push_back(it);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (light_q.size() > 0 || s_axis_tvalid_i || range_exp_q.size() > 0);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    thr_model = val;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    thr_model = 24'd1;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed lights under the reset threshold.
    light_q.push_back(make_light(16'h1000, 0, 0, 24'h100, 0, 0, 0));          // no attenuation
    light_q.push_back(make_light(16'h1000, 0, 0, 24'h100, 24'h10000, 0, 0));  // constant only
    light_q.push_back(make_light(16'h10, 0, 0, 24'h1, 24'h7FFFFF, 0, 24'h1)); // constant over peak
    light_q.push_back(make_light(0, 16'h1000, 0, 24'h100, 0, 0, 24'h10000));  // square-root form
    light_q.push_back(make_light(0, 0, 16'h1000, 24'h100, 24'h10000, 24'h800, 24'h100));
    light_q.push_back(make_light(16'h1000, 0, 0, 24'h100, 0, 24'h10000, 0));  // linear
    light_q.push_back(make_light(16'h1000, 0, 0, 24'h100, 24'h4000, 24'hFF0000, 0));
    light_q.push_back(make_light(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
                                 0, 24'h000001, 0));                          // overflow
    light_q.push_back(make_light(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
                                 24'h800000, 24'h800000, 24'h800000));        // most negative
    light_q.push_back(make_light(16'hFFFF, 0, 16'h1, 24'hFFFFFF, 24'h7FFFFF,
                                 24'h7FFFFF, 24'h7FFFFF));
    light_q.push_back(make_light(16'hFFFF, 0, 0, 24'hFFFFFF, 0, 0, 24'h000001));
    light_q.push_back(make_light(0, 0, 0, 0, 24'h1, 24'h1, 24'h1));           // zero peak
    light_q.push_back(make_light(16'h8000, 16'h4000, 16'h2000, 24'h800000,
                                 24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFD));
    queue_random(300);
    wait_idle();

    // Threshold 0: zero coefficients count as present, divisors can be zero.
    write_threshold(24'd0);
    light_q.push_back(make_light(16'h1000, 0, 0, 24'h100, 0, 0, 0));
    light_q.push_back(make_light(16'h1000, 0, 0, 24'h100, 24'h100, 0, 24'h100));
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    queue_random(300);
    wait_idle();

    // Maximum threshold: almost everything is absent.
    write_threshold(24'hFFFFFF);
    light_q.push_back(make_light(16'h1000, 0, 0, 24'h100, 24'h800000, 0, 0));
    src_idle_en = 1'b1;
    queue_random(200);
    wait_idle();

    write_threshold(24'h000100);
    snk_idle_en = 1'b1;
    queue_random(400);
    wait_idle();

    write_threshold(24'($urandom_range(1, 24'h20000)));
    src_idle_en = 1'b0;
    queue_random(450);
    wait_idle();

    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
